[src/nfjm_pkg.sv]
package nfjm_pkg;

   localparam int SAMPLE_W = 12;
   localparam int TIME_W = 32;
   localparam int SEL_W = 6;
   localparam int Y_W = 24;
   localparam int PEAK_W = 29;
   localparam int COUNT_W = 32;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 88;
   localparam int ACC_W = 36;
   localparam int DEV_W = 30;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [TIME_W-1:0] PERIOD_RESET = 32'd40000;
   localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};

   localparam logic signed [ACC_W-1:0] COEF_X1 = 36'sd503;
   localparam logic signed [ACC_W-1:0] COEF_Y1 = 36'sd498;
   localparam logic signed [ACC_W-1:0] COEF_Y2 = 36'sd251;
   localparam logic signed [ACC_W-1:0] ACC_ROUND = 36'sd128;
   localparam logic signed [ACC_W-1:0] Y_MAX = 36'sd8388607;
   localparam logic signed [ACC_W-1:0] Y_MIN = -36'sd8388608;
   localparam logic [TIME_W:0] DEV_ROUND = 33'd4;

   typedef struct packed {
      logic measured;
      logic [PEAK_W-1:0] peak_next;
   } jit_status_type;

endpackage

[src/nfjm_notch.sv]
module nfjm_notch (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic [nfjm_pkg::SAMPLE_W-1:0] sample,
   output logic signed [nfjm_pkg::Y_W-1:0] filtered
);

   logic [nfjm_pkg::SAMPLE_W-1:0] x1_ff;
   logic [nfjm_pkg::SAMPLE_W-1:0] x2_ff;
   logic signed [nfjm_pkg::Y_W-1:0] y1_ff;
   logic signed [nfjm_pkg::Y_W-1:0] y2_ff;

   logic signed [nfjm_pkg::ACC_W-1:0] xs;
   logic signed [nfjm_pkg::ACC_W-1:0] x1s;
   logic signed [nfjm_pkg::ACC_W-1:0] x2s;
   logic signed [nfjm_pkg::ACC_W-1:0] y1s;
   logic signed [nfjm_pkg::ACC_W-1:0] y2s;
   logic signed [nfjm_pkg::ACC_W-1:0] acc;
   logic signed [nfjm_pkg::ACC_W-1:0] quot;

   always_comb begin
      xs = nfjm_pkg::ACC_W'(signed'({1'b0, sample}));
      x1s = nfjm_pkg::ACC_W'(signed'({1'b0, x1_ff}));
      x2s = nfjm_pkg::ACC_W'(signed'({1'b0, x2_ff}));
      y1s = nfjm_pkg::ACC_W'(y1_ff);
      y2s = nfjm_pkg::ACC_W'(y2_ff);
      acc = ((xs + x2s) <<< 8) - x1s * nfjm_pkg::COEF_X1 + y1s * nfjm_pkg::COEF_Y1
            - y2s * nfjm_pkg::COEF_Y2 + nfjm_pkg::ACC_ROUND;
      // The shift rounds down; a negative value with a remainder moves up one to truncate.
      quot = acc >>> 8;
      if (acc[nfjm_pkg::ACC_W-1] && (acc[7:0] != 8'd0)) begin
         quot = quot + nfjm_pkg::ACC_W'(1);
      end
      if (quot > nfjm_pkg::Y_MAX) begin
         filtered = nfjm_pkg::Y_W'(nfjm_pkg::Y_MAX);
      end else if (quot < nfjm_pkg::Y_MIN) begin
         filtered = nfjm_pkg::Y_W'(nfjm_pkg::Y_MIN);
      end else begin
         filtered = nfjm_pkg::Y_W'(quot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else if (step) begin
         x2_ff <= x1_ff;
         x1_ff <= sample;
         y2_ff <= y1_ff;
         y1_ff <= filtered;
      end
   end

endmodule

[src/nfjm_jitter.sv]
module nfjm_jitter #(
   parameter int JITTER_BINS = 64,
   parameter int BIN_W = 6
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic [nfjm_pkg::TIME_W-1:0] csr_wr_data,
   input  logic step,
   input  logic [nfjm_pkg::TIME_W-1:0] now,
   output nfjm_pkg::jit_status_type status,
   output logic [BIN_W-1:0] bin,
   output logic [nfjm_pkg::PEAK_W-1:0] peak
);

   logic [nfjm_pkg::TIME_W-1:0] period_ff;
   logic [nfjm_pkg::TIME_W-1:0] prev_ff;
   logic seen_ff;
   logic [nfjm_pkg::PEAK_W-1:0] peak_ff;

   logic [nfjm_pkg::TIME_W-1:0] span;
   logic [nfjm_pkg::TIME_W-1:0] diff;
   logic [nfjm_pkg::TIME_W:0] diff_sum;
   logic [nfjm_pkg::DEV_W-1:0] dev_raw;
   logic [nfjm_pkg::PEAK_W-1:0] dev;
   logic [nfjm_pkg::PEAK_W-1:0] peak_in;

   always_comb begin
      span = now - prev_ff;
      diff = (span > period_ff) ? (span - period_ff) : (period_ff - span);
      diff_sum = {1'b0, diff} + nfjm_pkg::DEV_ROUND;
      dev_raw = diff_sum[nfjm_pkg::TIME_W:3];
      dev = (dev_raw > nfjm_pkg::DEV_W'(nfjm_pkg::PEAK_MAX)) ?
            nfjm_pkg::PEAK_MAX : dev_raw[nfjm_pkg::PEAK_W-1:0];
      if (nfjm_pkg::PEAK_W'(JITTER_BINS) <= dev) begin
         bin = BIN_W'(JITTER_BINS - 1);
      end else begin
         bin = dev[BIN_W-1:0];
      end
      peak_in = (seen_ff && (dev > peak_ff)) ? dev : peak_ff;
      status.measured = seen_ff;
      status.peak_next = peak_in;
   end

   assign peak = peak_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= nfjm_pkg::PERIOD_RESET;
         prev_ff <= '0;
         seen_ff <= 1'b0;
         peak_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
         if (step) begin
            prev_ff <= now;
            seen_ff <= 1'b1;
            peak_ff <= peak_in;
         end
      end
   end

endmodule

[src/nfjm_hist.sv]
module nfjm_hist #(
   parameter int JITTER_BINS = 64,
   parameter int BIN_W = 6
) (
   input  logic clock,
   input  logic reset,
   input  logic rd_en,
   input  logic [BIN_W-1:0] rd_addr,
   input  logic rd_zero,
   input  logic commit,
   output logic [nfjm_pkg::COUNT_W-1:0] count,
   output logic clearing
);

   logic [nfjm_pkg::COUNT_W-1:0] mem [JITTER_BINS];

   logic clear_ff;
   logic [BIN_W-1:0] clr_addr_ff;
   logic [nfjm_pkg::COUNT_W-1:0] rd_data_ff;
   logic [BIN_W-1:0] addr_ff;
   logic zero_ff;
   logic fwd_valid_ff;
   logic [BIN_W-1:0] fwd_addr_ff;
   logic [nfjm_pkg::COUNT_W-1:0] fwd_data_ff;

   logic wr_en;
   logic [BIN_W-1:0] wr_addr;
   logic [nfjm_pkg::COUNT_W-1:0] wr_data;

   always_comb begin
      // A write at the edge that loaded the read data is not in it; take it from the bypass.
      if (zero_ff) begin
         count = '0;
      end else if (fwd_valid_ff && (fwd_addr_ff == addr_ff)) begin
         count = fwd_data_ff;
      end else begin
         count = rd_data_ff;
      end
      if (clear_ff) begin
         wr_en = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en = commit;
         wr_addr = addr_ff;
         wr_data = count + nfjm_pkg::COUNT_W'(1);
      end
   end

   assign clearing = clear_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         addr_ff <= rd_addr;
         zero_ff <= rd_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         clr_addr_ff <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (clear_ff) begin
            clr_addr_ff <= clr_addr_ff + BIN_W'(1);
            if (clr_addr_ff == BIN_W'(JITTER_BINS - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         if (commit && !clear_ff) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         fwd_addr_ff <= addr_ff;
         fwd_data_ff <= wr_data;
      end
   end

endmodule

[src/notch_filter_with_jitter_monitor_top.sv]
// Notch filter and sample-interval jitter monitor. Each req item is either a converter sample
// (tuser low; dropped without a reply when run_enable is low) or a histogram bin read (tuser
// high). One item can be accepted every clock cycle while rsp is not stalled; a reply passes
// through the input, histogram and result registers before it leaves rsp. The filter feedback
// and the histogram read-modify-write (one memory read port, one write port, with a one-entry
// bypass) each complete without a stall between items, which sets that rate. After reset the
// histogram memory is cleared one bin per cycle, and req_tready stays low while it clears; csr
// writes are taken at any time.
module notch_filter_with_jitter_monitor_top #(
   parameter int JITTER_BINS = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic [nfjm_pkg::TIME_W-1:0] csr_wr_data,
   input  logic req_tvalid,
   output logic req_tready,
   // sample_value[11:0], sample_time[43:12], run_enable[44], bin_select[50:45], zero fill
   input  logic [nfjm_pkg::REQ_TDATA_W-1:0] req_tdata,
   // cmd[0]
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // filtered_value[23:0], max_jitter[52:24], bin_count[84:53], zero fill
   output logic [nfjm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // is_read_reply[0]
   output logic rsp_tuser
);

   localparam int BIN_W = $clog2(JITTER_BINS);

   // Input stage
   logic s1_valid_ff;
   logic s1_cmd_ff;
   logic [nfjm_pkg::SAMPLE_W-1:0] s1_sample_ff;
   logic [nfjm_pkg::TIME_W-1:0] s1_time_ff;
   logic [nfjm_pkg::SEL_W-1:0] s1_sel_ff;

   // Histogram stage
   logic s2_valid_ff;
   logic s2_read_ff;
   logic s2_commit_ff;
   logic signed [nfjm_pkg::Y_W-1:0] s2_y_ff;
   logic [nfjm_pkg::PEAK_W-1:0] s2_peak_ff;

   // Result register
   logic rsp_valid_ff;
   logic [nfjm_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic rsp_user_ff;

   logic out_free;
   logic s2_move;
   logic s2_free;
   logic s1_move;
   logic s1_free;
   logic req_accept;
   logic s1_is_sample;
   logic sample_step;

   logic signed [nfjm_pkg::Y_W-1:0] notch_y;
   nfjm_pkg::jit_status_type jit_status;
   logic [BIN_W-1:0] jit_bin;
   logic [nfjm_pkg::PEAK_W-1:0] jit_peak;
   logic [BIN_W-1:0] hist_rd_addr;
   logic hist_rd_zero;
   logic [nfjm_pkg::COUNT_W-1:0] hist_count;
   logic hist_clearing;
   logic [nfjm_pkg::SEL_W+BIN_W-1:0] sel_wide;
   logic s1_valid_in;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s2_move = s2_valid_ff && out_free;
   assign s2_free = !s2_valid_ff || out_free;
   assign s1_move = s1_valid_ff && s2_free;
   assign s1_free = !s1_valid_ff || s2_free;
   assign req_tready = s1_free && !hist_clearing;
   assign req_accept = req_tvalid && req_tready;
   assign s1_is_sample = (s1_cmd_ff == nfjm_pkg::CMD_SAMPLE);
   assign sample_step = s1_move && s1_is_sample;
   // A disabled sample is taken and dropped here.
   assign s1_valid_in = (req_tuser == nfjm_pkg::CMD_READ) || req_tdata[44];

   always_comb begin
      sel_wide = (nfjm_pkg::SEL_W + BIN_W)'(s1_sel_ff);
      if (s1_is_sample) begin
         hist_rd_addr = jit_bin;
         hist_rd_zero = 1'b0;
      end else begin
         hist_rd_addr = sel_wide[BIN_W-1:0];
         hist_rd_zero = !(sel_wide < (nfjm_pkg::SEL_W + BIN_W)'(JITTER_BINS));
      end
   end

   nfjm_notch u_notch (
      .clock    (clock),
      .reset    (reset),
      .step     (sample_step),
      .sample   (s1_sample_ff),
      .filtered (notch_y)
   );

   nfjm_jitter #(
      .JITTER_BINS (JITTER_BINS),
      .BIN_W       (BIN_W)
   ) u_jitter (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (sample_step),
      .now         (s1_time_ff),
      .status      (jit_status),
      .bin         (jit_bin),
      .peak        (jit_peak)
   );

   nfjm_hist #(
      .JITTER_BINS (JITTER_BINS),
      .BIN_W       (BIN_W)
   ) u_hist (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (s1_move),
      .rd_addr  (hist_rd_addr),
      .rd_zero  (hist_rd_zero),
      .commit   (s2_move && s2_commit_ff),
      .count    (hist_count),
      .clearing (hist_clearing)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= s1_valid_in;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_move) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff <= req_tuser;
         s1_sample_ff <= req_tdata[11:0];
         s1_time_ff <= req_tdata[43:12];
         s1_sel_ff <= req_tdata[50:45];
      end
      if (s1_move) begin
         s2_read_ff <= !s1_is_sample;
         s2_commit_ff <= s1_is_sample && jit_status.measured;
         s2_y_ff <= s1_is_sample ? notch_y : '0;
         s2_peak_ff <= s1_is_sample ? jit_status.peak_next : jit_peak;
      end
      if (s2_move) begin
         rsp_data_ff <= {3'b000, (s2_read_ff ? hist_count : nfjm_pkg::COUNT_W'(0)),
                         s2_peak_ff, s2_y_ff};
         rsp_user_ff <= s2_read_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      hist_clearing |-> !req_tready)
      else $error("item accepted while the histogram is being cleared");

   a_no_reply_while_clearing: assert property (@(posedge clock) disable iff (reset)
      hist_clearing |-> !rsp_tvalid)
      else $error("reply shown while the histogram is being cleared");

   a_peak_never_falls: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (jit_peak >= $past(jit_peak)))
      else $error("jitter peak decreased");

   a_reply_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser ? (rsp_tdata[23:0] == 24'd0) : (rsp_tdata[84:53] == 32'd0)))
      else $error("reply carries a field that belongs to the other kind of item");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

   typedef struct {
      logic                          cmd;
      logic [nfjm_pkg::SAMPLE_W-1:0] value;
      logic [nfjm_pkg::TIME_W-1:0]   stamp;
      logic                          run;
      logic [nfjm_pkg::SEL_W-1:0]    bin;
   } req_item_type;

   typedef struct {
      logic signed [nfjm_pkg::Y_W-1:0] filt;
      logic [nfjm_pkg::PEAK_W-1:0]     peak;
      logic [nfjm_pkg::COUNT_W-1:0]    count;
      logic                            is_read;
   } reply_type;

   localparam int NUM_BINS = 64;
   localparam int RANDOM_PER_PHASE = 135;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [nfjm_pkg::TIME_W-1:0] csr_wr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [nfjm_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [nfjm_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tuser;

   // Filter and jitter monitor state as the block should hold it.
   logic [nfjm_pkg::TIME_W-1:0]     period_model = nfjm_pkg::PERIOD_RESET;
   logic [nfjm_pkg::SAMPLE_W-1:0]   x_prev1 = '0;
   logic [nfjm_pkg::SAMPLE_W-1:0]   x_prev2 = '0;
   logic signed [nfjm_pkg::Y_W-1:0] y_prev1 = '0;
   logic signed [nfjm_pkg::Y_W-1:0] y_prev2 = '0;
   logic [nfjm_pkg::TIME_W-1:0]     last_stamp = '0;
   logic                            seen_first = 1'b0;
   logic [nfjm_pkg::PEAK_W-1:0]     peak_model = '0;
   logic [nfjm_pkg::COUNT_W-1:0]    bin_counts [NUM_BINS] = '{default: '0};

   req_item_type items_to_send[$];
   reply_type    replies_due[$];
   req_item_type on_bus;
   logic [nfjm_pkg::TIME_W-1:0] gen_stamp = '0;
   int errors = 0;
   int replies_seen = 0;
   int cyc = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   logic quiet;

   notch_filter_with_jitter_monitor_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cyc <= cyc + 1;
   end

   // A stretch in which neither side idles.
   assign quiet = (cyc >= 300 && cyc < 700);

   task automatic predict_reply(input req_item_type it);
      reply_type r;
      longint signed acc;
      longint signed q;
      logic signed [nfjm_pkg::Y_W-1:0] y;
      logic [nfjm_pkg::TIME_W-1:0] span;
      longint unsigned diff;
      longint unsigned dev;
      int b;
      if (it.cmd == nfjm_pkg::CMD_READ) begin
         r.filt = '0;
         r.peak = peak_model;
         r.count = bin_counts[it.bin];
         r.is_read = 1'b1;
         replies_due.push_back(r);
      end else if (it.run) begin
         acc = 256 * (longint'(it.value) + longint'(x_prev2)) - 503 * longint'(x_prev1)
               + 498 * longint'(y_prev1) - 251 * longint'(y_prev2) + 128;
         q = acc / 256;
         if (q > nfjm_pkg::Y_MAX) y = nfjm_pkg::Y_W'(nfjm_pkg::Y_MAX);
         else if (q < nfjm_pkg::Y_MIN) y = nfjm_pkg::Y_W'(nfjm_pkg::Y_MIN);
         else y = q[nfjm_pkg::Y_W-1:0];
         x_prev2 = x_prev1;
         x_prev1 = it.value;
         y_prev2 = y_prev1;
         y_prev1 = y;
         if (seen_first) begin
            span = it.stamp - last_stamp;
            if (span > period_model) diff = span - period_model;
            else diff = period_model - span;
            dev = (diff + 4) / 8;
            if (dev > nfjm_pkg::PEAK_MAX) dev = nfjm_pkg::PEAK_MAX;
            if (dev > peak_model) peak_model = dev[nfjm_pkg::PEAK_W-1:0];
            b = (dev >= NUM_BINS) ? NUM_BINS - 1 : int'(dev);
            bin_counts[b] = bin_counts[b] + 1;
         end
         seen_first = 1'b1;
         last_stamp = it.stamp;
         r.filt = y;
         r.peak = peak_model;
         r.count = '0;
         r.is_read = 1'b0;
         replies_due.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_reply(on_bus);
         if (!req_tvalid || req_tready) begin
            if (items_to_send.size() > 0 && (quiet || $urandom_range(99) >= 22)) begin
               on_bus = items_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {5'b0, on_bus.bin, on_bus.run, on_bus.stamp, on_bus.value};
               req_tuser <= on_bus.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : reply_check
      reply_type want;
      logic signed [nfjm_pkg::Y_W-1:0] got_filt;
      logic [nfjm_pkg::PEAK_W-1:0] got_peak;
      logic [nfjm_pkg::COUNT_W-1:0] got_count;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_filt = rsp_tdata[nfjm_pkg::Y_W-1:0];
            got_peak = rsp_tdata[nfjm_pkg::Y_W+nfjm_pkg::PEAK_W-1:nfjm_pkg::Y_W];
            got_count = rsp_tdata[nfjm_pkg::Y_W+nfjm_pkg::PEAK_W+nfjm_pkg::COUNT_W-1:
                                  nfjm_pkg::Y_W+nfjm_pkg::PEAK_W];
            replies_seen++;
            if (replies_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: reply with none due: filt=%0d peak=%0d count=%0d read=%b",
                           $realtime, got_filt, got_peak, got_count, rsp_tuser);
            end else begin
               want = replies_due.pop_front();
               if (got_filt !== want.filt || got_peak !== want.peak ||
                   got_count !== want.count || rsp_tuser !== want.is_read) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch: filt %0d/%0d peak %0d/%0d count %0d/%0d read %b/%b",
                              $realtime, want.filt, got_filt, want.peak, got_peak,
                              want.count, got_count, want.is_read, rsp_tuser);
               end
            end
         end
         // Hold off once for long enough that the block backs up into its input.
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && replies_seen >= 500 && items_to_send.size() > 100) begin
            hold_done = 1'b1;
            hold_left = 160;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || $urandom_range(99) >= 22;
         end
      end
   end

   task automatic add_sample(input logic [nfjm_pkg::SAMPLE_W-1:0] value,
                             input logic [nfjm_pkg::TIME_W-1:0] stamp,
                             input logic run);
      req_item_type it;
      it.cmd = nfjm_pkg::CMD_SAMPLE;
      it.value = value;
      it.stamp = stamp;
      it.run = run;
      it.bin = nfjm_pkg::SEL_W'($urandom_range(63));
      items_to_send.push_back(it);
      if (run) gen_stamp = stamp;
   endtask

   task automatic add_read(input logic [nfjm_pkg::SEL_W-1:0] bin);
      req_item_type it;
      it.cmd = nfjm_pkg::CMD_READ;
      it.value = nfjm_pkg::SAMPLE_W'($urandom_range(4095));
      it.stamp = $urandom();
      it.run = 1'($urandom_range(1));
      it.bin = bin;
      items_to_send.push_back(it);
   endtask

   // Mostly regular sample streams with jitter around the period, mixed with reads,
   // samples at arbitrary times and disabled samples.
   task automatic queue_random(input int n);
      int counted;
      int pick;
      int jit;
      logic [nfjm_pkg::SAMPLE_W-1:0] v;
      counted = 0;
      while (counted < n) begin
         pick = $urandom_range(99);
         v = ($urandom_range(99) < 15) ? ($urandom_range(1) ? 12'hFFF : 12'h000)
                                       : 12'($urandom_range(4095));
         if (pick < 62) begin
            case ($urandom_range(19))
               0, 1, 2: jit = int'($urandom_range(10000)) - 5000;
               3, 4, 5, 6, 7, 8, 9: jit = int'($urandom_range(1400)) - 700;
               default: jit = int'($urandom_range(300)) - 150;
            endcase
            add_sample(v, gen_stamp + period_model + jit, 1'b1);
            counted++;
         end else if (pick < 77) begin
            add_read(nfjm_pkg::SEL_W'(($urandom_range(99) < 60) ? $urandom_range(20)
                                                                : $urandom_range(63)));
            counted++;
         end else if (pick < 87) begin
            add_sample(v, $urandom(), 1'b1);
            counted++;
         end else begin
            add_sample(v, $urandom(), 1'b0);
         end
      end
   endtask

   task automatic drain();
      do @(negedge clock);
      while (items_to_send.size() != 0 || req_tvalid || replies_due.size() != 0);
      // Disabled samples leave no reply, so allow the pipeline to empty as well.
      repeat (8) @(posedge clock);
   endtask

   task automatic write_period(input logic [nfjm_pkg::TIME_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      period_model = value;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed items with the period left at its reset value.
      add_read(0);
      add_read(63);
      add_sample(12'hFFF, 32'd123, 1'b0);
      add_sample(12'hFFF, 32'hFFFF_FF00, 1'b1);
      add_sample(12'h000, gen_stamp + 40000, 1'b1);
      add_sample(12'hFFF, gen_stamp + 40003, 1'b1);
      add_sample(12'h000, gen_stamp + 40004, 1'b1);
      add_sample(12'hFFF, gen_stamp + 39996, 1'b1);
      add_sample(12'h000, gen_stamp + 40012, 1'b1);
      add_sample(12'hFFF, gen_stamp + 40511, 1'b1);
      add_sample(12'h000, gen_stamp + 39496, 1'b1);
      add_sample(12'hFFF, gen_stamp, 1'b1);
      add_sample(12'h800, 32'h5A5A_5A5A, 1'b0);
      add_sample(12'h800, gen_stamp + 40000, 1'b1);
      add_read(0);
      add_read(1);
      add_read(2);
      add_read(62);
      add_read(63);
      queue_random(RANDOM_PER_PHASE);
      drain();

      write_period($urandom());
      queue_random(RANDOM_PER_PHASE);
      drain();

      // A zero period is taken as it is, so the deviation is the interval itself divided by eight and rounded.
      write_period(32'd0);
      add_sample(12'h123, gen_stamp + 32'hFFFF_FFFF, 1'b1);
      add_sample(12'h456, gen_stamp, 1'b1);
      add_read(63);
      queue_random(RANDOM_PER_PHASE);
      drain();

      // The largest deviations saturate the jitter peak.
      write_period(32'd1);
      add_sample(12'hFFF, gen_stamp, 1'b1);
      add_sample(12'h000, gen_stamp + 2, 1'b1);
      add_sample(12'hFFF, gen_stamp + 32'hFFFF_FFFF, 1'b1);
      add_read(0);
      add_read(63);
      queue_random(RANDOM_PER_PHASE);
      drain();

      write_period(32'hFFFF_FFFF);
      add_sample(12'h000, gen_stamp, 1'b1);
      add_sample(12'hFFF, gen_stamp + 32'hFFFF_FFFF, 1'b1);
      add_read(63);
      queue_random(RANDOM_PER_PHASE);
      drain();

      write_period(nfjm_pkg::PERIOD_RESET);
      queue_random(RANDOM_PER_PHASE);
      drain();

      errors += replies_due.size();
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

endmodule

[filelist.f]
src/nfjm_pkg.sv
src/nfjm_notch.sv
src/nfjm_jitter.sv
src/nfjm_hist.sv
src/notch_filter_with_jitter_monitor_top.sv
bench/tb_top.sv
